// ----- sv/stuffed_frame_receiver_crc_check_unit_defines.svh -----
// Assertion macros shared by the checker.
`ifndef STUFFED_FRAME_RECEIVER_CRC_CHECK_UNIT_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_CRC_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFRCC_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sfrcc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SFRCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sfrcc: next-cycle check failed");

`endif

// ----- sv/sfrcc_pkg.sv -----
package sfrcc_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h7E;
  localparam logic [7:0] START_BYTE = 8'hA5;
  localparam logic [7:0] END_BYTE   = 8'hA6;

  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_VALID   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // register map, word index = paddr[3:2]
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_POLY     = 2'd1;
  localparam logic [1:0] REG_SEED     = 2'd2;

  localparam logic [7:0]  CAPACITY_RST = 8'd64;
  localparam logic [15:0] POLY_RST     = 16'h1021;
  localparam logic [15:0] SEED_RST     = 16'hFFFF;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_BEGIN,
    ACT_DATA,
    ACT_END,
    ACT_ABORT
  } action_e;

  typedef struct packed {
    action_e    act;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic [7:0]  capacity;
    logic [15:0] poly;
    logic [15:0] seed;
  } cfg_t;

  // one byte into an MSB-first CRC16, no reflection
  function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- sv/sfrcc_front.sv -----
module sfrcc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output sfrcc_pkg::entry_t   entry_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_STUFF  = 3'd3;
  localparam logic [2:0] ST_DATA   = 3'd4;
  localparam logic [2:0] ST_END    = 3'd5;

  logic [2:0]          state_q, state_d;
  sfrcc_pkg::action_e  act;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    state_d = ST_IDLE;
    act     = sfrcc_pkg::ACT_NONE;
    case (state_q)
      ST_SEARCH: begin
        if (rx_byte_i == sfrcc_pkg::START_BYTE) begin
          state_d = ST_START;
          act     = sfrcc_pkg::ACT_BEGIN;
        end else if (rx_byte_i == sfrcc_pkg::ESC_BYTE) begin
          state_d = ST_SEARCH;
        end else begin
          act     = sfrcc_pkg::ACT_ABORT;
        end
      end
      ST_START, ST_DATA: begin
        if (rx_byte_i == sfrcc_pkg::ESC_BYTE) begin
          state_d = ST_STUFF;
        end else begin
          state_d = ST_DATA;
          act     = sfrcc_pkg::ACT_DATA;
        end
      end
      ST_STUFF: begin
        if (rx_byte_i == sfrcc_pkg::START_BYTE) begin
          state_d = ST_START;
          act     = sfrcc_pkg::ACT_BEGIN;
        end else if (rx_byte_i == sfrcc_pkg::END_BYTE) begin
          state_d = ST_END;
          act     = sfrcc_pkg::ACT_END;
        end else if (rx_byte_i == sfrcc_pkg::ESC_BYTE) begin
          // doubled escape is a literal 0x7E
          state_d = ST_DATA;
          act     = sfrcc_pkg::ACT_DATA;
        end else begin
          act     = sfrcc_pkg::ACT_ABORT;
        end
      end
      default: begin
        // idle, end and unused codes
        state_d = (rx_byte_i == sfrcc_pkg::ESC_BYTE) ? ST_SEARCH : ST_IDLE;
      end
    endcase
  end

  assign entry_o.act  = act;
  assign entry_o.data = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else if (push_o) begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/sfrcc_queue.sv -----
module sfrcc_queue #(
  parameter int unsigned DEPTH = sfrcc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfrcc_pkg::entry_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output sfrcc_pkg::entry_t  head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sfrcc_pkg::entry_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o       = (count_q == CNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/sfrcc_back.sv -----
module sfrcc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfrcc_pkg::cfg_t    cfg_i,
  input  logic               head_valid_i,
  input  sfrcc_pkg::entry_t  head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         frame_status_o,
  output logic               store_valid_o,
  output logic [7:0]         store_byte_o,
  output logic [7:0]         store_index_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  pos_q, pos_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic        stv_q, stv_d;
  logic [7:0]  sbyte_q, sbyte_d;
  logic [7:0]  sidx_q, sidx_d;
  logic        room;

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);
  assign room  = (pos_q < cfg_i.capacity);

  always_comb begin
    crc_d       = crc_q;
    pos_d       = pos_q;
    status_d    = sfrcc_pkg::STATUS_NONE;
    stv_d       = 1'b0;
    sbyte_d     = '0;
    sidx_d      = '0;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      out_valid_d = 1'b1;
      case (head_i.act)
        sfrcc_pkg::ACT_BEGIN: begin
          crc_d = cfg_i.seed;
          pos_d = '0;
        end
        sfrcc_pkg::ACT_DATA: begin
          crc_d = sfrcc_pkg::crc_feed(crc_q, head_i.data, cfg_i.poly);
          if (room) begin
            stv_d   = 1'b1;
            sbyte_d = head_i.data;
            sidx_d  = pos_q;
            pos_d   = pos_q + 1'b1;
          end
        end
        sfrcc_pkg::ACT_END: begin
          status_d = (crc_q == '0) ? sfrcc_pkg::STATUS_VALID : sfrcc_pkg::STATUS_INVALID;
        end
        sfrcc_pkg::ACT_ABORT: begin
          status_d = sfrcc_pkg::STATUS_INVALID;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= sfrcc_pkg::SEED_RST;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      stv_q    <= stv_d;
      sbyte_q  <= sbyte_d;
      sidx_q   <= sidx_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign store_valid_o  = stv_q;
  assign store_byte_o   = sbyte_q;
  assign store_index_o  = sidx_q;

endmodule

// ----- sv/stuffed_frame_receiver_crc_check_unit.sv -----
// Byte-stuffing deframer with CRC16 check.
// Input channel: one received byte per item on rx_byte_i, handshake
//   in_valid_i / in_stall_o. Output channel: one result per input byte
//   (frame_status_o, store_valid_o, store_byte_o, store_index_o) on
//   out_valid_o / out_stall_i.
// Path: a byte accepted into the classifier queue waits there until the
//   CRC/store stage pops it, and its result is then presented from the
//   result register; a stall on out_stall_i can hold it in the queue.
// Throughput: one byte per cycle while the result is not stalled; the back
//   end's byte-wide CRC update and position counter are combinational.
// When the receiver stalls, the result register holds and the queue
//   (QUEUE_DEPTH entries) absorbs bytes until full, then in_stall_o rises.
// Reset: deframer goes idle, CRC loads 0xFFFF, write position clears,
//   queue and result register empty; capacity 64, polynomial 0x1021,
//   seed 0xFFFF. Registers (APB, word addresses 0x0, 0x4, 0x8) should be
//   written only while no item is in flight.
module stuffed_frame_receiver_crc_check_unit #(
  parameter int unsigned QUEUE_DEPTH = sfrcc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfrcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   frame_status_o,
  output logic                         store_valid_o,
  output logic [7:0]                   store_byte_o,
  output logic [7:0]                   store_index_o
);

  sfrcc_pkg::cfg_t   cfg_q;
  sfrcc_pkg::entry_t push_entry, head_entry;
  logic              push, full, pop, head_valid;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity <= sfrcc_pkg::CAPACITY_RST;
      cfg_q.poly     <= sfrcc_pkg::POLY_RST;
      cfg_q.seed     <= sfrcc_pkg::SEED_RST;
    end else if (wr_en) begin
      case (reg_idx)
        sfrcc_pkg::REG_CAPACITY: cfg_q.capacity <= pwdata[7:0];
        sfrcc_pkg::REG_POLY:     cfg_q.poly     <= pwdata[15:0];
        sfrcc_pkg::REG_SEED:     cfg_q.seed     <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfrcc_pkg::REG_CAPACITY: prdata = {24'd0, cfg_q.capacity};
      sfrcc_pkg::REG_POLY:     prdata = {16'd0, cfg_q.poly};
      sfrcc_pkg::REG_SEED:     prdata = {16'd0, cfg_q.seed};
      default:                 prdata = '0;
    endcase
  end

  sfrcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .full_i     (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sfrcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_entry)
  );

  sfrcc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_valid_i   (head_valid),
    .head_i         (head_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_status_o (frame_status_o),
    .store_valid_o  (store_valid_o),
    .store_byte_o   (store_byte_o),
    .store_index_o  (store_index_o)
  );

endmodule

// ----- sv/sfrcc_checker.sv -----
`include "stuffed_frame_receiver_crc_check_unit_defines.svh"

module sfrcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] frame_status_o,
  input logic       store_valid_o,
  input logic [7:0] store_byte_o,
  input logic [7:0] store_index_o
);

  logic        held;
  logic [18:0] res_bits;
  logic        no_status;
  logic        store_zero;
  logic        status_ok;

  assign held       = out_valid_o && out_stall_i;
  assign res_bits   = {frame_status_o, store_valid_o, store_byte_o, store_index_o};
  assign no_status  = (frame_status_o == sfrcc_pkg::STATUS_NONE);
  assign store_zero = (store_byte_o == 8'd0) && (store_index_o == 8'd0);
  assign status_ok  = no_status || (frame_status_o == sfrcc_pkg::STATUS_VALID) ||
                      (frame_status_o == sfrcc_pkg::STATUS_INVALID);

  // a stalled result holds
  `SFRCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, held, out_valid_o && $stable(res_bits))

  // a stored byte never carries a frame decision
  `SFRCC_ASSERT_NOW(a_store_no_status, clk_i, rst_ni, out_valid_o && store_valid_o, no_status)

  // no store: byte and index read as zero
  `SFRCC_ASSERT_NOW(a_nostore_zero, clk_i, rst_ni, out_valid_o && !store_valid_o, store_zero)

  // status is one of the three defined codes
  `SFRCC_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o, status_ok)

endmodule

bind stuffed_frame_receiver_crc_check_unit sfrcc_checker u_sfrcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .frame_status_o (frame_status_o),
  .store_valid_o  (store_valid_o),
  .store_byte_o   (store_byte_o),
  .store_index_o  (store_index_o)
);
